// File: rtl/core/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the insertion sorter and its cells.
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // per-cycle command that every cell of the chain sees
   typedef struct packed {
      logic insert;   // place the new item or shift up
      logic drain;    // shift down towards the output end
   } cell_ctrl_type;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_DRAIN
   } sort_state_type;

endpackage

// File: rtl/core/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorting chain: compare against the new item, hold, take it,
// shift up from the lower neighbour or shift down from the upper neighbour.
// ----------------------------------------------------------------------------
module isort_cell (
   input  logic                     clock,
   input  isort_pkg::cell_ctrl_type ctrl,
   input  isort_pkg::value_type     new_value,
   input  isort_pkg::value_type     left_value,
   input  logic                     left_gt,
   input  isort_pkg::value_type     right_value,
   input  logic                     occupied,
   input  logic                     at_fill,
   output isort_pkg::value_type     value,
   output logic                     gt
);
   import isort_pkg::*;

   value_type value_ff;
   value_type value_in;

   // strictly greater only, so equal items keep their arrival order
   assign gt    = occupied && (value_ff > new_value);
   assign value = value_ff;

   always_comb begin
      priority if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert && left_gt) begin
         value_in = left_value;
      end else if (ctrl.insert && (gt || at_fill)) begin
         value_in = new_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: rtl/core/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Latency: an item that fits is inserted in the cycle it is accepted; after
//   the item marked tlast the first result is offered in the next cycle.
// Throughput: one input item per cycle while filling, then one result per cycle
//   while draining and rsp_tready; the chain moves once per stored item or result.
// Reset: synchronous, active high; clears fill count, drop flag and state.
// ----------------------------------------------------------------------------
module insertion_sorter #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // [31:0] value
   input  logic                      req_tlast,   // last item of the run
   // result items
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // [31:0] sorted_value
   output logic                      rsp_tlast,   // last_out
   output logic [0:0]                rsp_tuser    // [0] overflow
);
   import isort_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // control state
   sort_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;

   // chain wiring
   value_type       cell_value [CAPACITY];
   logic            cell_gt    [CAPACITY];
   cell_ctrl_type   ctrl;

   logic            req_fire;
   logic            rsp_fire;
   logic            full;
   value_type       new_value;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign new_value = value_type'(req_tdata);

   // next state: drain after the run's last item, return to filling once
   // the final result has gone
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && (count_ff == CNT_W'(1))) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // outputs and chain commands; within each state the command follows the
   // other side's handshake line directly, as the ready or valid is fixed there
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            req_tready  = 1'b1;
            ctrl.insert = req_tvalid && !full;
         end
         ST_DRAIN: begin
            rsp_tvalid  = 1'b1;
            ctrl.drain  = rsp_tready;
         end
         default: begin
            req_tready  = 1'b0;
         end
      endcase
   end

   // fill count doubles as the remaining-results count while draining;
   // a full store drops the item and marks the run
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      priority if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (req_fire && full) begin
         dropped_in = 1'b1;
      end else if (ctrl.drain) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            dropped_in = 1'b0;
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // chain of cells: cell 0 holds the smallest entry and feeds the output
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_v;
      value_type right_v;
      logic      left_g;

      if (i == 0) begin : g_first
         assign left_v = new_value;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_g = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_v = new_value;
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .occupied    (CNT_W'(i) < count_ff),
         .at_fill     (CNT_W'(i) == count_ff),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   assign rsp_tdata    = cell_value[0];
   assign rsp_tlast    = (count_ff == CNT_W'(1));
   assign rsp_tuser[0] = dropped_ff;

   // never accept and offer in the same cycle
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result channels active together");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty store");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> rsp_tvalid)
      else $error("no result after the last item of a run");

   a_final_refills: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (req_tready && (count_ff == '0) && !dropped_ff))
      else $error("store not emptied after the final result");

endmodule
